### rtl/mwd_pkg.sv
// Package with types, constants and tap tables of the multilevel wavelet decomposer.
package mwd_pkg;

    // Fixed widths and limits of the block.
    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int MAX_LEVELS      = 9;
    localparam int TAP_FRAC_BITS   = 16;
    localparam int TAP_W           = 18;
    localparam int MAX_TAPS        = 9;
    localparam int LVL_DEPTH       = 16;

    // Configuration register indexes.
    localparam logic REG_WAVELET_TYPE = 1'b0;
    localparam logic REG_LEVEL_LIMIT  = 1'b1;

    // Item kinds.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_LVL,
        ST_MAC,
        ST_DRAIN,
        ST_WRITE,
        ST_RESP
    } state_t;

    // Control word from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic       vld;
        logic       clear;
        logic [3:0] k;
        logic [1:0] wt;
    } mac_ctl_t;

    typedef logic signed [TAP_W-1:0] tap_t;

    // Low-pass taps in Q2.16, rounded to nearest.
    function automatic tap_t tap_lo(input logic [1:0] wt, input logic [3:0] k);
        tap_t r;
        r = '0;
        case (wt)
            2'd0: case (k)
                4'd0, 4'd1: r = 18'sd46341;
                default:    r = '0;
            endcase
            2'd1: case (k)
                4'd0:    r = 18'sd31651;
                4'd1:    r = 18'sd54822;
                4'd2:    r = 18'sd14689;
                4'd3:    r = -18'sd8481;
                default: r = '0;
            endcase
            2'd2: case (k)
                4'd0:    r = 18'sd15098;
                4'd1:    r = 18'sd46848;
                4'd2:    r = 18'sd41345;
                4'd3:    r = -18'sd1834;
                4'd4:    r = -18'sd12258;
                4'd5:    r = 18'sd2021;
                4'd6:    r = 18'sd2155;
                4'd7:    r = -18'sd694;
                default: r = '0;
            endcase
            default: case (k)
                4'd0, 4'd8: r = 18'sd1753;
                4'd1, 4'd7: r = -18'sd1105;
                4'd2, 4'd6: r = -18'sd5126;
                4'd3, 4'd5: r = 18'sd17489;
                4'd4:       r = 18'sd39515;
                default:    r = '0;
            endcase
        endcase
        return r;
    endfunction

    // High-pass taps in Q2.16, rounded to nearest.
    function automatic tap_t tap_hi(input logic [1:0] wt, input logic [3:0] k);
        tap_t r;
        r = '0;
        case (wt)
            2'd0: case (k)
                4'd0:    r = 18'sd46341;
                4'd1:    r = -18'sd46341;
                default: r = '0;
            endcase
            2'd1: case (k)
                4'd0:    r = -18'sd8481;
                4'd1:    r = -18'sd14689;
                4'd2:    r = 18'sd54822;
                4'd3:    r = -18'sd31651;
                default: r = '0;
            endcase
            2'd2: case (k)
                4'd0:    r = -18'sd694;
                4'd1:    r = -18'sd2155;
                4'd2:    r = 18'sd2021;
                4'd3:    r = 18'sd12258;
                4'd4:    r = -18'sd1834;
                4'd5:    r = -18'sd41345;
                4'd6:    r = 18'sd46848;
                4'd7:    r = -18'sd15098;
                default: r = '0;
            endcase
            default: case (k)
                4'd1, 4'd7: r = 18'sd5982;
                4'd2, 4'd6: r = -18'sd3771;
                4'd3, 4'd5: r = -18'sd38750;
                4'd4:       r = 18'sd73078;
                default:    r = '0;
            endcase
        endcase
        return r;
    endfunction

    // Number of taps of each filter set.
    function automatic logic [3:0] tap_count(input logic [1:0] wt);
        logic [3:0] r;
        case (wt)
            2'd0:    r = 4'd2;
            2'd1:    r = 4'd4;
            2'd2:    r = 4'd8;
            default: r = 4'd9;
        endcase
        return r;
    endfunction

endpackage

### rtl/mwd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mwd_ram #(
    parameter int W = 32,
    parameter int D = 1024
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic                 re,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem [D];
    logic [W-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/mwd_mac.sv
// Shared multiply-accumulate unit for the low and high filter with rounding and saturation.
module mwd_mac (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mwd_pkg::mac_ctl_t      ctl,
    input  logic signed [31:0]     x,
    output logic signed [31:0]     lo_q,
    output logic signed [31:0]     hi_q
);

    localparam int PROD_W = 32 + mwd_pkg::TAP_W;
    localparam int ACC_W  = PROD_W + 6;
    localparam int Q_W    = ACC_W - mwd_pkg::TAP_FRAC_BITS;

    logic                     p_vld_reg;
    logic signed [PROD_W-1:0] p_lo_reg;
    logic signed [PROD_W-1:0] p_hi_reg;
    logic signed [ACC_W-1:0]  acc_lo_reg;
    logic signed [ACC_W-1:0]  acc_hi_reg;

    // Product valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
        end
        else
        begin
            p_vld_reg <= ctl.vld;
        end
    end

    // Product stage, then accumulate stage.
    always_ff @(posedge clk)
    begin
        if (ctl.vld)
        begin
            p_lo_reg <= x * mwd_pkg::tap_lo(ctl.wt, ctl.k);
            p_hi_reg <= x * mwd_pkg::tap_hi(ctl.wt, ctl.k);
        end
        if (ctl.clear)
        begin
            acc_lo_reg <= '0;
            acc_hi_reg <= '0;
        end
        else if (p_vld_reg)
        begin
            acc_lo_reg <= acc_lo_reg + ACC_W'(p_lo_reg);
            acc_hi_reg <= acc_hi_reg + ACC_W'(p_hi_reg);
        end
    end

    // Round half up, drop the tap fraction and saturate to 32 bits.
    function automatic logic signed [31:0] round_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] t;
        logic signed [Q_W-1:0]   q;
        logic signed [31:0]      r;
        t = a + (ACC_W'(1) <<< (mwd_pkg::TAP_FRAC_BITS - 1));
        q = Q_W'(t >>> mwd_pkg::TAP_FRAC_BITS);
        if (q > Q_W'(32'sh7fff_ffff))
            r = 32'sh7fff_ffff;
        else if (q < -(Q_W'(33'sh0_8000_0000)))
            r = 32'sh8000_0000;
        else
            r = q[31:0];
        return r;
    endfunction

    assign lo_q = round_sat(acc_lo_reg);
    assign hi_q = round_sat(acc_hi_reg);

endmodule

### rtl/multilevel_wavelet_decomposer.sv
// Top level of the multilevel periodic wavelet decomposer.
// A load item is taken only in idle; the item with the last mark then starts the transform.
// For each output pair the transform issues the taps to the shared MAC unit, drains it and
// writes the result, level by level over all levels; no item is taken meanwhile.
// A read item reads both stores; its result is registered once the output register is free.
// Reset is asynchronous, active low; it clears control state, the stores stay undefined.
module multilevel_wavelet_decomposer #(
    parameter int MAX_SAMPLES = mwd_pkg::MAX_SAMPLES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sample[15:0], read_level[19:16], read_index[28:20]
    input  logic        s_tuser,   // kind
    input  logic        s_tlast,   // last_sample
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // approx[31:0], detail[63:32], levels_done[67:64],
                                   // level_length[77:68], in_range[78]
    // Configuration writes.
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data
);

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = AW + 1;
    localparam int SW = CW + 10;

    mwd_pkg::state_t state_reg, state_next;

    logic [1:0]    wavelet_type_reg;
    logic [3:0]    level_limit_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          start_new_reg, start_new_next;
    logic [3:0]    levels_reg, levels_next;
    logic [1:0]    wt_reg, wt_next;
    logic [3:0]    limit_reg, limit_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] half_reg, half_next;
    logic [AW-1:0] in_off_reg, in_off_next;
    logic [AW-1:0] out_off_reg, out_off_next;
    logic [AW-1:0] i_reg, i_next;
    logic [AW-1:0] base_reg, base_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [3:0]    k_reg, k_next;
    logic [1:0]    drain_reg, drain_next;
    logic          issue_d_reg;
    logic [3:0]    k_d_reg;
    logic [CW-1:0] lvl_len_reg [mwd_pkg::LVL_DEPTH];
    logic [AW-1:0] lvl_off_reg [mwd_pkg::LVL_DEPTH];
    logic          rd_ok_reg, rd_ok_next;
    logic [CW-1:0] rd_len_reg, rd_len_next;
    logic          out_vld_reg;
    logic [79:0]   out_data_reg;

    logic          accept;
    logic          lvl_wr;
    logic          issue;
    logic          out_load;
    logic          sig_we;
    logic [AW-1:0] sig_waddr;
    logic          apx_re;
    logic [AW-1:0] apx_raddr;
    logic          det_re;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] mac_addr;
    logic          res_we;
    logic [31:0]   sig_q, apx_q, det_q;
    logic signed [31:0] lo_q, hi_q;
    logic [CW-1:0] count_eff;
    logic [3:0]    rd_lvl;
    logic [3:0]    rd_sel;
    logic [8:0]    rd_idx;
    logic          lvl_ok;
    logic [SW-1:0] rd_sum;
    logic [3:0]    lim_clamped;
    mwd_pkg::mac_ctl_t mac_ctl;

    assign s_tready = (state_reg == mwd_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign rd_lvl   = s_tdata[19:16];
    assign rd_idx   = s_tdata[28:20];
    assign rd_sel   = rd_lvl - 4'd1;
    assign lvl_ok   = (rd_lvl != 4'd0) && (rd_lvl <= levels_reg);
    assign rd_sum   = SW'(lvl_off_reg[rd_sel]) + SW'(rd_idx);
    assign rd_addr  = rd_sum[AW-1:0];
    assign mac_addr = in_off_reg + pos_reg;
    assign count_eff = start_new_reg ? '0 : count_reg;

    // Level limit clamped into the supported range.
    always_comb
    begin
        if (level_limit_reg == 4'd0)
            lim_clamped = 4'd1;
        else if (level_limit_reg > 4'(mwd_pkg::MAX_LEVELS))
            lim_clamped = 4'(mwd_pkg::MAX_LEVELS);
        else
            lim_clamped = level_limit_reg;
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wavelet_type_reg <= 2'd0;
            level_limit_reg  <= 4'd3;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mwd_pkg::REG_WAVELET_TYPE: wavelet_type_reg <= cfg_data[1:0];
                mwd_pkg::REG_LEVEL_LIMIT:  level_limit_reg  <= cfg_data;
                default:                   wavelet_type_reg <= wavelet_type_reg;
            endcase
        end
    end

    // Sequencer: loading, level setup, tap reads, drain, result write and read response.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        start_new_next = start_new_reg;
        levels_next    = levels_reg;
        wt_next        = wt_reg;
        limit_next     = limit_reg;
        n_next         = n_reg;
        half_next      = half_reg;
        in_off_next    = in_off_reg;
        out_off_next   = out_off_reg;
        i_next         = i_reg;
        base_next      = base_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        drain_next     = drain_reg;
        rd_ok_next     = rd_ok_reg;
        rd_len_next    = rd_len_reg;
        sig_we         = 1'b0;
        sig_waddr      = count_eff[AW-1:0];
        apx_re         = 1'b0;
        apx_raddr      = mac_addr;
        det_re         = 1'b0;
        issue          = 1'b0;
        res_we         = 1'b0;
        lvl_wr         = 1'b0;
        out_load       = 1'b0;
        mac_ctl.vld    = issue_d_reg;
        mac_ctl.clear  = 1'b0;
        mac_ctl.k      = k_d_reg;
        mac_ctl.wt     = wt_reg;
        unique case (state_reg)
            mwd_pkg::ST_IDLE:
            begin
                if (accept && s_tuser == mwd_pkg::KIND_LOAD)
                begin
                    start_new_next = 1'b0;
                    count_next     = count_eff;
                    if (count_eff < CW'(MAX_SAMPLES))
                    begin
                        sig_we     = 1'b1;
                        count_next = count_eff + CW'(1);
                    end
                    if (s_tlast)
                    begin
                        start_new_next = 1'b1;
                        state_next     = mwd_pkg::ST_START;
                    end
                end
                else if (accept)
                begin
                    rd_len_next = lvl_ok ? lvl_len_reg[rd_sel] : '0;
                    rd_ok_next  = lvl_ok && (SW'(rd_idx) < SW'(lvl_len_reg[rd_sel]));
                    apx_re      = 1'b1;
                    det_re      = 1'b1;
                    apx_raddr   = rd_addr;
                    state_next  = mwd_pkg::ST_RESP;
                end
            end
            mwd_pkg::ST_START:
            begin
                wt_next       = wavelet_type_reg;
                limit_next    = lim_clamped;
                n_next        = count_reg;
                levels_next   = 4'd0;
                in_off_next   = '0;
                out_off_next  = '0;
                mac_ctl.clear = 1'b1;
                state_next    = mwd_pkg::ST_LVL;
            end
            mwd_pkg::ST_LVL:
            begin
                if (levels_reg < limit_reg && n_reg >= CW'(4))
                begin
                    lvl_wr     = 1'b1;
                    half_next  = n_reg >> 1;
                    i_next     = '0;
                    base_next  = '0;
                    pos_next   = '0;
                    k_next     = 4'd0;
                    state_next = mwd_pkg::ST_MAC;
                end
                else
                begin
                    state_next = mwd_pkg::ST_IDLE;
                end
            end
            mwd_pkg::ST_MAC:
            begin
                issue  = 1'b1;
                apx_re = 1'b1;
                k_next = k_reg + 4'd1;
                if (CW'(pos_reg) + CW'(1) == n_reg)
                    pos_next = '0;
                else
                    pos_next = pos_reg + AW'(1);
                if (k_reg == mwd_pkg::tap_count(wt_reg) - 4'd1)
                begin
                    drain_next = 2'd0;
                    state_next = mwd_pkg::ST_DRAIN;
                end
            end
            mwd_pkg::ST_DRAIN:
            begin
                drain_next = drain_reg + 2'd1;
                if (drain_reg == 2'd1)
                    state_next = mwd_pkg::ST_WRITE;
            end
            mwd_pkg::ST_WRITE:
            begin
                res_we        = 1'b1;
                mac_ctl.clear = 1'b1;
                if (CW'(i_reg) + CW'(1) == half_reg)
                begin
                    levels_next  = levels_reg + 4'd1;
                    in_off_next  = out_off_reg;
                    out_off_next = out_off_reg + half_reg[AW-1:0];
                    n_next       = half_reg;
                    state_next   = mwd_pkg::ST_LVL;
                end
                else
                begin
                    i_next     = i_reg + AW'(1);
                    base_next  = base_reg + AW'(2);
                    pos_next   = base_reg + AW'(2);
                    k_next     = 4'd0;
                    state_next = mwd_pkg::ST_MAC;
                end
            end
            mwd_pkg::ST_RESP:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = mwd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mwd_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mwd_pkg::ST_IDLE;
            count_reg     <= '0;
            start_new_reg <= 1'b1;
            levels_reg    <= 4'd0;
            issue_d_reg   <= 1'b0;
            out_vld_reg   <= 1'b0;
            lvl_len_reg   <= '{default: '0};
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            start_new_reg <= start_new_next;
            levels_reg    <= levels_next;
            issue_d_reg   <= issue;
            if (lvl_wr)
                lvl_len_reg[levels_reg] <= n_reg >> 1;
            if (out_load)
                out_vld_reg <= 1'b1;
            else if (m_tready)
                out_vld_reg <= 1'b0;
        end
    end

    // Working registers of the transform and the read path.
    always_ff @(posedge clk)
    begin
        wt_reg      <= wt_next;
        limit_reg   <= limit_next;
        n_reg       <= n_next;
        half_reg    <= half_next;
        in_off_reg  <= in_off_next;
        out_off_reg <= out_off_next;
        i_reg       <= i_next;
        base_reg    <= base_next;
        pos_reg     <= pos_next;
        k_reg       <= k_next;
        drain_reg   <= drain_next;
        k_d_reg     <= k_reg;
        rd_ok_reg   <= rd_ok_next;
        rd_len_reg  <= rd_len_next;
        if (lvl_wr)
            lvl_off_reg[levels_reg] <= out_off_reg;
        if (out_load)
        begin
            out_data_reg[31:0]  <= rd_ok_reg ? apx_q : 32'd0;
            out_data_reg[63:32] <= rd_ok_reg ? det_q : 32'd0;
            out_data_reg[67:64] <= levels_reg;
            out_data_reg[77:68] <= 10'(rd_len_reg);
            out_data_reg[78]    <= rd_ok_reg;
            out_data_reg[79]    <= 1'b0;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    // Sample, approximation and detail stores.
    mwd_ram #(.W(32), .D(MAX_SAMPLES)) u_sig_ram (
        .clk   (clk),
        .we    (sig_we),
        .waddr (sig_waddr),
        .wdata ({{8{s_tdata[15]}}, s_tdata[15:0], 8'd0}),
        .re    (issue),
        .raddr (mac_addr),
        .rdata (sig_q)
    );

    mwd_ram #(.W(32), .D(MAX_SAMPLES)) u_apx_ram (
        .clk   (clk),
        .we    (res_we),
        .waddr (out_off_reg + i_reg),
        .wdata (lo_q),
        .re    (apx_re),
        .raddr (apx_raddr),
        .rdata (apx_q)
    );

    mwd_ram #(.W(32), .D(MAX_SAMPLES)) u_det_ram (
        .clk   (clk),
        .we    (res_we),
        .waddr (out_off_reg + i_reg),
        .wdata (hi_q),
        .re    (det_re),
        .raddr (rd_addr),
        .rdata (det_q)
    );

    // Shared multiply-accumulate unit; level one reads the sample store.
    mwd_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .x     ((levels_reg == 4'd0) ? sig_q : apx_q),
        .lo_q  (lo_q),
        .hi_q  (hi_q)
    );

endmodule

### rtl/mwd_checker.sv
// Port-level checker of the wavelet decomposer and its bind to the top level.
module mwd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);

    // A waiting result item stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    // An index in range implies a level with coefficients.
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[78] |-> m_tdata[77:68] != 10'd0)
        else $error("in-range result with zero level length");

    // A bad read returns zero coefficients.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[78] |-> m_tdata[63:0] == 64'd0)
        else $error("out-of-range result with nonzero coefficients");

    // The level count never passes the maximum depth.
    a_lvls: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[67:64] <= 4'd9)
        else $error("levels_done above maximum");

endmodule

bind multilevel_wavelet_decomposer mwd_checker u_mwd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/tb_multilevel_wavelet_decomposer.sv
// Self-checking testbench for the multilevel wavelet decomposer: loads signals, reads coefficients.
module tb_multilevel_wavelet_decomposer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIG_CAP    = 1024;
    localparam int IDLE_LIMIT = 400000;

    // One coefficient read result.
    typedef struct packed {
        logic        in_range;
        logic [9:0]  level_length;
        logic [3:0]  levels_done;
        logic signed [31:0] detail;
        logic signed [31:0] approx;
    } coeff_pair_t;

    // Predicts the block and holds the expected read results in order.
    class wavelet_scoreboard;
        int signed sig_mem [SIG_CAP];
        int signed lo_mem [SIG_CAP];
        int signed hi_mem [SIG_CAP];
        int unsigned sig_count;
        int unsigned level_count;
        int unsigned last_length;
        bit fresh_signal;
        logic [1:0] filter_sel;
        logic [3:0] max_levels;
        coeff_pair_t pending_pairs[$];
        int errors;

        function new();
            sig_count = 0;
            level_count = 0;
            last_length = 0;
            fresh_signal = 1;
            filter_sel = 2'd0;
            max_levels = 4'd3;
            errors = 0;
        endfunction

        function void set_reg(logic idx, logic [3:0] val);
            if (idx == mwd_pkg::REG_WAVELET_TYPE)
                filter_sel = val[1:0];
            else
                max_levels = val;
        endfunction

        // Floor of (acc + half) >> frac bits, saturated to 32 bits.
        function int signed round_saturate(longint signed acc);
            longint signed q;
            q = (acc + (64'sd1 <<< (mwd_pkg::TAP_FRAC_BITS - 1))) >>> mwd_pkg::TAP_FRAC_BITS;
            if (q > 64'sd2147483647)
                return 32'sh7fffffff;
            if (q < -64'sd2147483648)
                return 32'sh80000000;
            return int'(q);
        endfunction

        // Tap tables derived independently from the filter constants.
        function longint signed tap_value(bit high_pass, int k);
            longint signed lo_t [4][9] = '{
                '{46341, 46341, 0, 0, 0, 0, 0, 0, 0},
                '{31651, 54822, 14689, -8481, 0, 0, 0, 0, 0},
                '{15098, 46848, 41345, -1834, -12258, 2021, 2155, -694, 0},
                '{1753, -1105, -5126, 17489, 39515, 17489, -5126, -1105, 1753}};
            longint signed hi_t [4][9] = '{
                '{46341, -46341, 0, 0, 0, 0, 0, 0, 0},
                '{-8481, -14689, 54822, -31651, 0, 0, 0, 0, 0},
                '{-694, -2155, 2021, 12258, -1834, -41345, 46848, -15098, 0},
                '{0, 5982, -3771, -38750, 73078, -38750, -3771, 5982, 0}};
            return high_pass ? hi_t[filter_sel][k] : lo_t[filter_sel][k];
        endfunction

        function void run_transform();
            int unsigned n_taps, lim, n, half, in_off, out_off, idx;
            longint signed ls, hs, x;
            bit from_signal;
            n_taps = (filter_sel == 0) ? 2 : (filter_sel == 1) ? 4 : (filter_sel == 2) ? 8 : 9;
            lim = (max_levels < 1) ? 1 :
                  (max_levels > mwd_pkg::MAX_LEVELS) ? mwd_pkg::MAX_LEVELS : max_levels;
            n = sig_count;
            in_off = 0;
            out_off = 0;
            from_signal = 1;
            last_length = n;
            level_count = 0;
            while (level_count < lim && n >= 4)
            begin
                half = n / 2;
                for (int i = 0; i < half; i++)
                begin
                    ls = 0;
                    hs = 0;
                    for (int k = 0; k < n_taps; k++)
                    begin
                        idx = (2 * i + k) % n;
                        x = from_signal ? sig_mem[idx] : lo_mem[in_off + idx];
                        ls += x * tap_value(0, k);
                        hs += x * tap_value(1, k);
                    end
                    lo_mem[out_off + i] = round_saturate(ls);
                    hi_mem[out_off + i] = round_saturate(hs);
                end
                from_signal = 0;
                in_off = out_off;
                out_off += half;
                n = half;
                level_count++;
            end
        endfunction

        // Notes one accepted input item.
        function void note_item(logic kind, logic signed [15:0] smp, logic last,
                                logic [3:0] lvl, logic [8:0] idx);
            coeff_pair_t e;
            int unsigned len, off, n;
            if (kind == mwd_pkg::KIND_LOAD)
            begin
                if (fresh_signal)
                begin
                    sig_count = 0;
                    fresh_signal = 0;
                end
                if (sig_count < SIG_CAP)
                begin
                    sig_mem[sig_count] = int'(smp) * 256;
                    sig_count++;
                end
                if (last)
                begin
                    run_transform();
                    fresh_signal = 1;
                end
            end
            else
            begin
                e = '0;
                e.levels_done = level_count[3:0];
                if (lvl >= 1 && lvl <= level_count)
                begin
                    n = last_length;
                    off = 0;
                    len = 0;
                    for (int l = 1; l <= lvl; l++)
                    begin
                        len = n / 2;
                        if (l < lvl)
                            off += len;
                        n = len;
                    end
                    e.level_length = len[9:0];
                    if (idx < len)
                    begin
                        e.approx = lo_mem[off + idx];
                        e.detail = hi_mem[off + idx];
                        e.in_range = 1;
                    end
                end
                pending_pairs.push_back(e);
            end
        endfunction

        task report(string what, longint got, longint want);
            errors++;
            if (errors <= 30)
                $display("mismatch %s: got %0d expected %0d", what, got, want);
        endtask

        // Checks one accepted result against the oldest expectation.
        task check_pair(logic [79:0] raw);
            coeff_pair_t e, g;
            g = raw[78:0];
            if (pending_pairs.size() == 0)
            begin
                report("unexpected result", 1, 0);
                return;
            end
            e = pending_pairs.pop_front();
            if (g.approx !== e.approx)
                report("approx", g.approx, e.approx);
            if (g.detail !== e.detail)
                report("detail", g.detail, e.detail);
            if (g.levels_done !== e.levels_done)
                report("levels_done", g.levels_done, e.levels_done);
            if (g.level_length !== e.level_length)
                report("level_length", g.level_length, e.level_length);
            if (g.in_range !== e.in_range)
                report("in_range", g.in_range, e.in_range);
        endtask
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [79:0] m_tdata;
    logic        cfg_we = 0;
    logic        cfg_index = 0;
    logic [3:0]  cfg_data = '0;

    wavelet_scoreboard sb;
    int send_idle_pct = 10;
    int recv_idle_pct = 62;
    bit recv_hold = 0;
    int quiet_cycles = 0;
    int reads_sent = 0;
    int signals_sent = 0;

    always #5 clk = ~clk;

    multilevel_wavelet_decomposer u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Result side: random stalls, check on every accepted result.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_pair(m_tdata);
        m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog on cycles with no accepted item.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("timeout waiting for a handshake");
            $display("tb: failure");
            $finish;
        end
    end

    // Offers one item and waits for its acceptance.
    task automatic send_item(logic kind, logic signed [15:0] smp, logic last,
                             logic [3:0] lvl, logic [8:0] idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= kind;
        s_tlast <= last;
        s_tdata <= {3'b0, idx, lvl, smp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_item(kind, smp, last, lvl, idx);
        if (kind == mwd_pkg::KIND_READ)
            reads_sent++;
        else if (last)
            signals_sent++;
    endtask

    task automatic write_reg(logic idx, logic [3:0] val);
        s_tvalid <= 0;
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        sb.set_reg(idx, val);
    endtask

    // Waits until every expected result has arrived and the transform is done.
    task automatic drain();
        s_tvalid <= 0;
        @(posedge clk);
        while (sb.pending_pairs.size() != 0 || !s_tready || m_tvalid)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_signal(int len, int mode);
        logic signed [15:0] v;
        for (int i = 0; i < len; i++)
        begin
            case (mode)
                0: v = 16'sh7fff;
                1: v = 16'sh8000;
                2: v = (i % 2) ? 16'sh8000 : 16'sh7fff;
                default: v = 16'($urandom);
            endcase
            send_item(mwd_pkg::KIND_LOAD, v, i == len - 1, 4'($urandom), 9'($urandom));
        end
    endtask

    task automatic read_some(int cnt, int len);
        int lv, n;
        logic [8:0] ix;
        for (int i = 0; i < cnt; i++)
        begin
            lv = $urandom_range(10) < 8 ? $urandom_range(1, sb.level_count + 1)
                                       : $urandom_range(0, 15);
            n = len;
            for (int l = 0; l < lv && l < 16; l++)
                n = n / 2;
            ix = ($urandom_range(9) < 8 && n > 0) ? 9'($urandom_range(n - 1)) : 9'($urandom);
            send_item(mwd_pkg::KIND_READ, 16'($urandom), 1'($urandom), 4'(lv), ix);
        end
    endtask

    int len;
    initial
    begin
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: reads before any signal, short signal, extreme samples.
        send_item(mwd_pkg::KIND_READ, 16'sd0, 1'b0, 4'd1, 9'd0);
        send_item(mwd_pkg::KIND_READ, 16'sh7fff, 1'b1, 4'd15, 9'd511);
        load_signal(3, 3);
        send_item(mwd_pkg::KIND_READ, 16'sd0, 1'b0, 4'd1, 9'd0);
        drain();
        write_reg(mwd_pkg::REG_LEVEL_LIMIT, 4'd9);
        load_signal(8, 0);
        read_some(3, 8);
        drain();
        write_reg(mwd_pkg::REG_WAVELET_TYPE, 4'd3);
        write_reg(mwd_pkg::REG_LEVEL_LIMIT, 4'd0);
        load_signal(16, 2);
        read_some(3, 16);
        drain();
        write_reg(mwd_pkg::REG_WAVELET_TYPE, 4'd2);
        write_reg(mwd_pkg::REG_LEVEL_LIMIT, 4'd15);
        load_signal(9, 1);
        read_some(4, 9);
        drain();

        // Random phases with changing idling and settings; one signal overflows the store.
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 62 : 0;
            recv_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 10 : 0;
            for (int s = 0; s < 4; s++)
            begin
                drain();
                write_reg(mwd_pkg::REG_WAVELET_TYPE, 4'($urandom_range(3)));
                write_reg(mwd_pkg::REG_LEVEL_LIMIT, 4'($urandom_range(15)));
                len = (ph == 2 && s == 1) ? 1026 : $urandom_range(2, 30);
                load_signal(len, 3);
                if (s == 2)
                begin
                    // Long receiver hold while reads keep coming.
                    fork
                        begin
                            recv_hold = 1;
                            repeat (300) @(posedge clk);
                            recv_hold = 0;
                        end
                    join_none
                end
                read_some(8, len);
            end
        end
        drain();

        $display("covered %0d decompositions and %0d reads over all filter sets",
                 signals_sent, reads_sent);
        $display("with stalls on both sides and one signal longer than the store");
        if (sb.errors == 0 && sb.pending_pairs.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

### filelist.f
rtl/mwd_pkg.sv
rtl/mwd_ram.sv
rtl/mwd_mac.sv
rtl/multilevel_wavelet_decomposer.sv
rtl/mwd_checker.sv
tb/tb_multilevel_wavelet_decomposer.sv
